@@ rtl/pfma_pkg.sv @@
// ----------------------------------------------------------------------------
// pfma_pkg: shared types, widths and microcode for the force accumulator
// Control word layout, datapath selects and the sequencer program table.
// ----------------------------------------------------------------------------
package pfma_pkg;

  // field widths
  localparam int unsigned PosW  = 32;
  localparam int unsigned SizeW = 31;
  localparam int unsigned ChiW  = 17;
  localparam int unsigned InvW  = 31;
  localparam int unsigned ValW  = 64;
  localparam int unsigned AccW  = 2 * ValW;
  localparam int unsigned KW    = 33;
  localparam int unsigned TW    = 49;
  localparam int unsigned S2W   = 62;
  localparam int unsigned DW    = 33;
  localparam int unsigned PcW   = 7;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [ValW-1:0] SatMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] SatMin = {1'b1, {(ValW-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_USE_CHI,
    REG_FORCE_GAIN,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_INV_NORM_X,
    REG_INV_NORM_Y,
    REG_INV_NORM_M
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_IDLE,
    OP_LOAD,
    OP_MUL,
    OP_FIN1,
    OP_FIN2,
    OP_SUM,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    SA_GAIN,
    SA_K,
    SA_S,
    SA_TX,
    SA_TY,
    SA_FX,
    SA_FY,
    SA_SFX,
    SA_SFY,
    SA_SM
  } src_a_e;

  typedef enum logic [3:0] {
    SB_CHI,
    SB_U,
    SB_V,
    SB_S,
    SB_S2,
    SB_DX,
    SB_DY,
    SB_INX,
    SB_INY,
    SB_INM
  } src_b_e;

  typedef enum logic [3:0] {
    DST_K,
    DST_S2,
    DST_TX,
    DST_TY,
    DST_FX,
    DST_FY,
    DST_M,
    DST_CX,
    DST_CY,
    DST_CM
  } dst_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_CHI,
    CND_FX_LE0,
    CND_FY_LE0,
    CND_NOT_LAST
  } cond_e;

  typedef struct packed {
    op_e              op;
    src_a_e           sa;
    src_b_e           sb;
    logic             ah;
    logic             bh;
    logic             sh16;
    dst_e             dst;
    cond_e            cond;
    logic [PcW-1:0]   tgt;
  } uop_t;

  typedef struct packed {
    logic             use_chi;
    logic [PosW-1:0]  force_gain;
    logic [InvW-1:0]  inv_norm_x;
    logic [InvW-1:0]  inv_norm_y;
    logic [InvW-1:0]  inv_norm_m;
  } cfg_t;

  typedef struct packed {
    logic [DW-1:0]    dx;
    logic [DW-1:0]    dy;
    logic [PosW-1:0]  u;
    logic [PosW-1:0]  v;
    logic [SizeW-1:0] s;
    logic [ChiW-1:0]  chi;
    logic             last;
  } item_t;

  typedef struct packed {
    logic fx_le0;
    logic fy_le0;
  } stat_t;

  // program labels
  localparam logic [PcW-1:0] L_IDLE = 7'd0;
  localparam logic [PcW-1:0] L_S2   = 7'd6;
  localparam logic [PcW-1:0] L_CHKX = 7'd50;
  localparam logic [PcW-1:0] L_TAIL = 7'd59;

  function automatic uop_t uw(input op_e op, input src_a_e sa, input src_b_e sb,
                              input logic ah, input logic bh, input logic sh16,
                              input dst_e dst, input cond_e cond,
                              input logic [PcW-1:0] tgt);
    uop_t u;
    u.op   = op;
    u.sa   = sa;
    u.sb   = sb;
    u.ah   = ah;
    u.bh   = bh;
    u.sh16 = sh16;
    u.dst  = dst;
    u.cond = cond;
    u.tgt  = tgt;
    return u;
  endfunction

  function automatic uop_t u_nop();
    return uw(OP_NOP, SA_GAIN, SB_CHI, 1'b0, 1'b0, 1'b0, DST_K, CND_NEVER, L_IDLE);
  endfunction

  function automatic uop_t u_load(input src_a_e sa, input src_b_e sb, input cond_e cond,
                                  input logic [PcW-1:0] tgt);
    return uw(OP_LOAD, sa, sb, 1'b0, 1'b0, 1'b0, DST_K, cond, tgt);
  endfunction

  function automatic uop_t u_mul(input logic ah, input logic bh);
    return uw(OP_MUL, SA_GAIN, SB_CHI, ah, bh, 1'b0, DST_K, CND_NEVER, L_IDLE);
  endfunction

  function automatic uop_t u_fin1(input logic sh16);
    return uw(OP_FIN1, SA_GAIN, SB_CHI, 1'b0, 1'b0, sh16, DST_K, CND_NEVER, L_IDLE);
  endfunction

  function automatic uop_t u_fin2(input dst_e dst);
    return uw(OP_FIN2, SA_GAIN, SB_CHI, 1'b0, 1'b0, 1'b0, dst, CND_NEVER, L_IDLE);
  endfunction

  function automatic uop_t u_sum(input dst_e dst, input cond_e cond,
                                 input logic [PcW-1:0] tgt);
    return uw(OP_SUM, SA_GAIN, SB_CHI, 1'b0, 1'b0, 1'b0, dst, cond, tgt);
  endfunction

  // each multiply: load operands, partial products, drain, round, write back
  function automatic uop_t ucode_rom(input logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      // wait for a particle, skip the mask product in direct form
      7'd0:  u = uw(OP_IDLE, SA_GAIN, SB_CHI, 1'b0, 1'b0, 1'b0, DST_K, CND_NO_CHI, L_S2);
      // k = gain * chi
      7'd1:  u = u_load(SA_GAIN, SB_CHI, CND_NEVER, L_IDLE);
      7'd2:  u = u_mul(1'b0, 1'b0);
      7'd3:  u = u_nop();
      7'd4:  u = u_fin1(1'b1);
      7'd5:  u = u_fin2(DST_K);
      // s2 = s * s, exact
      7'd6:  u = u_load(SA_S, SB_S, CND_NEVER, L_IDLE);
      7'd7:  u = u_mul(1'b0, 1'b0);
      7'd8:  u = u_nop();
      7'd9:  u = u_fin1(1'b0);
      7'd10: u = u_fin2(DST_S2);
      // tx = k * u
      7'd11: u = u_load(SA_K, SB_U, CND_NEVER, L_IDLE);
      7'd12: u = u_mul(1'b0, 1'b0);
      7'd13: u = u_mul(1'b1, 1'b0);
      7'd14: u = u_nop();
      7'd15: u = u_fin1(1'b1);
      7'd16: u = u_fin2(DST_TX);
      // fx = tx * s2
      7'd17: u = u_load(SA_TX, SB_S2, CND_NEVER, L_IDLE);
      7'd18: u = u_mul(1'b0, 1'b0);
      7'd19: u = u_mul(1'b0, 1'b1);
      7'd20: u = u_mul(1'b1, 1'b0);
      7'd21: u = u_mul(1'b1, 1'b1);
      7'd22: u = u_nop();
      7'd23: u = u_fin1(1'b1);
      7'd24: u = u_fin2(DST_FX);
      // ty = k * v
      7'd25: u = u_load(SA_K, SB_V, CND_NEVER, L_IDLE);
      7'd26: u = u_mul(1'b0, 1'b0);
      7'd27: u = u_mul(1'b1, 1'b0);
      7'd28: u = u_nop();
      7'd29: u = u_fin1(1'b1);
      7'd30: u = u_fin2(DST_TY);
      // fy = ty * s2
      7'd31: u = u_load(SA_TY, SB_S2, CND_NEVER, L_IDLE);
      7'd32: u = u_mul(1'b0, 1'b0);
      7'd33: u = u_mul(1'b0, 1'b1);
      7'd34: u = u_mul(1'b1, 1'b0);
      7'd35: u = u_mul(1'b1, 1'b1);
      7'd36: u = u_nop();
      7'd37: u = u_fin1(1'b1);
      7'd38: u = u_fin2(DST_FY);
      7'd39: u = u_sum(DST_FX, CND_NEVER, L_IDLE);
      7'd40: u = u_sum(DST_FY, CND_FY_LE0, L_CHKX);
      // moment of fy about the centre
      7'd41: u = u_load(SA_FY, SB_DX, CND_NEVER, L_IDLE);
      7'd42: u = u_mul(1'b0, 1'b0);
      7'd43: u = u_mul(1'b0, 1'b1);
      7'd44: u = u_mul(1'b1, 1'b0);
      7'd45: u = u_mul(1'b1, 1'b1);
      7'd46: u = u_nop();
      7'd47: u = u_fin1(1'b1);
      7'd48: u = u_fin2(DST_M);
      7'd49: u = u_sum(DST_M, CND_NEVER, L_IDLE);
      // moment of fx about the centre
      7'd50: u = u_load(SA_FX, SB_DY, CND_FX_LE0, L_TAIL);
      7'd51: u = u_mul(1'b0, 1'b0);
      7'd52: u = u_mul(1'b0, 1'b1);
      7'd53: u = u_mul(1'b1, 1'b0);
      7'd54: u = u_mul(1'b1, 1'b1);
      7'd55: u = u_nop();
      7'd56: u = u_fin1(1'b1);
      7'd57: u = u_fin2(DST_M);
      7'd58: u = u_sum(DST_M, CND_NEVER, L_IDLE);
      // coefficients, only on the last particle
      7'd59: u = u_load(SA_SFX, SB_INX, CND_NOT_LAST, L_IDLE);
      7'd60: u = u_mul(1'b0, 1'b0);
      7'd61: u = u_mul(1'b1, 1'b0);
      7'd62: u = u_nop();
      7'd63: u = u_fin1(1'b1);
      7'd64: u = u_fin2(DST_CX);
      7'd65: u = u_load(SA_SFY, SB_INY, CND_NEVER, L_IDLE);
      7'd66: u = u_mul(1'b0, 1'b0);
      7'd67: u = u_mul(1'b1, 1'b0);
      7'd68: u = u_nop();
      7'd69: u = u_fin1(1'b1);
      7'd70: u = u_fin2(DST_CY);
      7'd71: u = u_load(SA_SM, SB_INM, CND_NEVER, L_IDLE);
      7'd72: u = u_mul(1'b0, 1'b0);
      7'd73: u = u_mul(1'b1, 1'b0);
      7'd74: u = u_nop();
      7'd75: u = u_fin1(1'b1);
      7'd76: u = u_fin2(DST_CM);
      7'd77: u = uw(OP_EMIT, SA_GAIN, SB_CHI, 1'b0, 1'b0, 1'b0, DST_K, CND_ALWAYS, L_IDLE);
      default: u = uw(OP_NOP, SA_GAIN, SB_CHI, 1'b0, 1'b0, 1'b0, DST_K, CND_ALWAYS, L_IDLE);
    endcase
    return u;
  endfunction

endpackage

@@ rtl/pfma_if.sv @@
// ----------------------------------------------------------------------------
// pfma_if: particle and result channels of the force accumulator
// Valid/ready channels carrying one particle or one set of totals per word.
// ----------------------------------------------------------------------------
interface pfma_in_if import pfma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PosW-1:0]  pos_x;
  logic signed [PosW-1:0]  pos_y;
  logic signed [PosW-1:0]  vel_u;
  logic signed [PosW-1:0]  vel_v;
  logic        [SizeW-1:0] core_size;
  logic        [ChiW-1:0]  solid_mask;
  logic                    last_particle;

  modport source (
    output valid, pos_x, pos_y, vel_u, vel_v, core_size, solid_mask, last_particle,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, vel_u, vel_v, core_size, solid_mask, last_particle,
    output ready
  );
endinterface

interface pfma_out_if import pfma_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] total_force_x;
  logic signed [ValW-1:0] total_force_y;
  logic signed [ValW-1:0] total_moment;
  logic signed [ValW-1:0] coeff_x;
  logic signed [ValW-1:0] coeff_y;
  logic signed [ValW-1:0] coeff_m;

  modport source (
    output valid, total_force_x, total_force_y, total_moment, coeff_x, coeff_y, coeff_m,
    input  ready
  );
  modport sink (
    input  valid, total_force_x, total_force_y, total_moment, coeff_x, coeff_y, coeff_m,
    output ready
  );
endinterface

@@ rtl/penalization_force_moment_accumulator.sv @@
// ----------------------------------------------------------------------------
// penalization_force_moment_accumulator: particle force and moment integral
// Microcoded sequencer over one shared multiplier; APB configuration port.
// ----------------------------------------------------------------------------
// each particle runs the program, which issues its partial products to the
//   single 32x32 multiplier (fewer without mask product or with non-positive
//   forces); the next particle is taken only back at the idle step, and a last
//   particle also runs the coefficient products; totals follow those products,
//   later only while an earlier result is still held at the output
// reset: registers take their reset values, sums clear at once, no clearing pass
module penalization_force_moment_accumulator import pfma_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  pfma_in_if.sink          in_i,
  pfma_out_if.source       out_o
);

  cfg_t            cfg_q;
  logic [PosW-1:0] center_x_q, center_y_q;
  item_t           item_q;
  logic [PcW-1:0]  pc_q, pc_d;
  uop_t            uop, uop_act;
  stat_t           stat;
  logic            hold, jump, in_fire, out_free, emit_fire, cfg_wr;
  logic            out_valid_q;
  logic [ValW-1:0] sum_fx, sum_fy, sum_m, coef_x, coef_y, coef_m;
  logic [ValW-1:0] ofx_q, ofy_q, om_q, ocx_q, ocy_q, ocm_q;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_chi    <= 1'b1;
      cfg_q.force_gain <= 32'd65536;
      center_x_q       <= '0;
      center_y_q       <= '0;
      cfg_q.inv_norm_x <= 31'd65536;
      cfg_q.inv_norm_y <= 31'd65536;
      cfg_q.inv_norm_m <= 31'd65536;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[AddrW-1:2]))
        REG_USE_CHI:    cfg_q.use_chi    <= pwdata[0];
        REG_FORCE_GAIN: cfg_q.force_gain <= pwdata;
        REG_CENTER_X:   center_x_q       <= pwdata;
        REG_CENTER_Y:   center_y_q       <= pwdata;
        REG_INV_NORM_X: cfg_q.inv_norm_x <= pwdata[InvW-1:0];
        REG_INV_NORM_Y: cfg_q.inv_norm_y <= pwdata[InvW-1:0];
        REG_INV_NORM_M: cfg_q.inv_norm_m <= pwdata[InvW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[AddrW-1:2]))
      REG_USE_CHI:    prdata = {{(DataW-1){1'b0}}, cfg_q.use_chi};
      REG_FORCE_GAIN: prdata = cfg_q.force_gain;
      REG_CENTER_X:   prdata = center_x_q;
      REG_CENTER_Y:   prdata = center_y_q;
      REG_INV_NORM_X: prdata = {1'b0, cfg_q.inv_norm_x};
      REG_INV_NORM_Y: prdata = {1'b0, cfg_q.inv_norm_y};
      REG_INV_NORM_M: prdata = {1'b0, cfg_q.inv_norm_m};
      default:        prdata = '0;
    endcase
  end

  // sequencer
  assign uop      = ucode_rom(pc_q);
  assign in_i.ready = (uop.op == OP_IDLE);
  assign in_fire  = in_i.valid & in_i.ready;
  assign out_free = ~out_valid_q | out_o.ready;
  assign hold     = ((uop.op == OP_IDLE) & ~in_i.valid) | ((uop.op == OP_EMIT) & ~out_free);
  assign emit_fire = (uop.op == OP_EMIT) & out_free;

  always_comb begin
    case (uop.cond)
      CND_NEVER:    jump = 1'b0;
      CND_ALWAYS:   jump = 1'b1;
      CND_NO_CHI:   jump = ~cfg_q.use_chi;
      CND_FX_LE0:   jump = stat.fx_le0;
      CND_FY_LE0:   jump = stat.fy_le0;
      CND_NOT_LAST: jump = ~item_q.last;
      default:      jump = 1'b0;
    endcase
    if (hold) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = uop.tgt;
    end else begin
      pc_d = pc_q + 7'd1;
    end
    uop_act = uop;
    if (hold) begin
      uop_act.op = OP_NOP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= L_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // particle capture, lever arms formed on the way in
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.dx   <= {center_x_q[PosW-1], center_x_q} - {in_i.pos_x[PosW-1], in_i.pos_x};
      item_q.dy   <= {in_i.pos_y[PosW-1], in_i.pos_y} - {center_y_q[PosW-1], center_y_q};
      item_q.u    <= in_i.vel_u;
      item_q.v    <= in_i.vel_v;
      item_q.s    <= in_i.core_size;
      item_q.chi  <= in_i.solid_mask;
      item_q.last <= in_i.last_particle;
    end
  end

  pfma_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .uop_i    (uop_act),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .stat_o   (stat),
    .sum_fx_o (sum_fx),
    .sum_fy_o (sum_fy),
    .sum_m_o  (sum_m),
    .coef_x_o (coef_x),
    .coef_y_o (coef_y),
    .coef_m_o (coef_m)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      ofx_q <= sum_fx;
      ofy_q <= sum_fy;
      om_q  <= sum_m;
      ocx_q <= coef_x;
      ocy_q <= coef_y;
      ocm_q <= coef_m;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.total_force_x = ofx_q;
  assign out_o.total_force_y = ofy_q;
  assign out_o.total_moment  = om_q;
  assign out_o.coeff_x       = ocx_q;
  assign out_o.coeff_y       = ocy_q;
  assign out_o.coeff_m       = ocm_q;

endmodule

@@ rtl/pfma_dp.sv @@
// ----------------------------------------------------------------------------
// pfma_dp: shared multiply datapath and accumulators
// One 32x32 multiplier builds each product from partial products into a
// 128-bit accumulator, then rounds toward minus infinity and saturates.
// ----------------------------------------------------------------------------
module pfma_dp import pfma_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  uop_t            uop_i,
  input  cfg_t            cfg_i,
  input  item_t           item_i,
  output stat_t           stat_o,
  output logic [ValW-1:0] sum_fx_o,
  output logic [ValW-1:0] sum_fy_o,
  output logic [ValW-1:0] sum_m_o,
  output logic [ValW-1:0] coef_x_o,
  output logic [ValW-1:0] coef_y_o,
  output logic [ValW-1:0] coef_m_o
);

  logic [ValW-1:0] a_val, b_val, a_mag, b_mag;
  logic [ValW-1:0] opa_q, opb_q;
  logic            neg_q;
  logic [31:0]     pa, pb;
  logic [ValW-1:0] pp, prod_q;
  logic [1:0]      off_q;
  logic            pvld_q;
  logic [AccW-1:0] acc_q;
  logic [AccW-1:0] q, qc;
  logic            rem;
  logic [ValW-1:0] mag_q;
  logic            big_q;
  logic [ValW-1:0] res;

  logic [KW-1:0]   k_q;
  logic [S2W-1:0]  s2_q;
  logic [TW-1:0]   tx_q, ty_q;
  logic [ValW-1:0] fx_q, fy_q, m_q;
  logic [ValW-1:0] cx_q, cy_q, cm_q;
  logic [ValW-1:0] sfx_q, sfy_q, sm_q;

  logic [ValW-1:0] sum_a, sum_b, sum_s, sum_r;
  logic            sum_ovf;

  // operand selects, all taken as signed 64-bit values
  always_comb begin
    case (uop_i.sa)
      SA_GAIN: a_val = {{(ValW-PosW){cfg_i.force_gain[PosW-1]}}, cfg_i.force_gain};
      SA_K:    a_val = cfg_i.use_chi ? {{(ValW-KW){k_q[KW-1]}}, k_q}
                                     : {{(ValW-PosW){cfg_i.force_gain[PosW-1]}},
                                        cfg_i.force_gain};
      SA_S:    a_val = {{(ValW-SizeW){1'b0}}, item_i.s};
      SA_TX:   a_val = {{(ValW-TW){tx_q[TW-1]}}, tx_q};
      SA_TY:   a_val = {{(ValW-TW){ty_q[TW-1]}}, ty_q};
      SA_FX:   a_val = fx_q;
      SA_FY:   a_val = fy_q;
      SA_SFX:  a_val = sfx_q;
      SA_SFY:  a_val = sfy_q;
      SA_SM:   a_val = sm_q;
      default: a_val = '0;
    endcase
  end

  always_comb begin
    case (uop_i.sb)
      SB_CHI:  b_val = {{(ValW-ChiW){1'b0}}, item_i.chi};
      SB_U:    b_val = {{(ValW-PosW){item_i.u[PosW-1]}}, item_i.u};
      SB_V:    b_val = {{(ValW-PosW){item_i.v[PosW-1]}}, item_i.v};
      SB_S:    b_val = {{(ValW-SizeW){1'b0}}, item_i.s};
      SB_S2:   b_val = {{(ValW-S2W){1'b0}}, s2_q};
      SB_DX:   b_val = {{(ValW-DW){item_i.dx[DW-1]}}, item_i.dx};
      SB_DY:   b_val = {{(ValW-DW){item_i.dy[DW-1]}}, item_i.dy};
      SB_INX:  b_val = {{(ValW-InvW){1'b0}}, cfg_i.inv_norm_x};
      SB_INY:  b_val = {{(ValW-InvW){1'b0}}, cfg_i.inv_norm_y};
      SB_INM:  b_val = {{(ValW-InvW){1'b0}}, cfg_i.inv_norm_m};
      default: b_val = '0;
    endcase
  end

  // magnitudes, so the most negative value still fits
  assign a_mag = a_val[ValW-1] ? (~a_val + 64'd1) : a_val;
  assign b_mag = b_val[ValW-1] ? (~b_val + 64'd1) : b_val;

  assign pa = uop_i.ah ? opa_q[63:32] : opa_q[31:0];
  assign pb = uop_i.bh ? opb_q[63:32] : opb_q[31:0];
  assign pp = {32'd0, pa} * {32'd0, pb};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= (uop_i.op == OP_MUL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (uop_i.op == OP_LOAD) begin
      opa_q <= a_mag;
      opb_q <= b_mag;
      neg_q <= a_val[ValW-1] ^ b_val[ValW-1];
    end
    if (uop_i.op == OP_MUL) begin
      prod_q <= pp;
      off_q  <= 2'(uop_i.ah) + 2'(uop_i.bh);
    end
    if (uop_i.op == OP_LOAD) begin
      acc_q <= '0;
    end else if (pvld_q) begin
      acc_q <= acc_q + ({{(AccW-ValW){1'b0}}, prod_q} << {off_q, 5'd0});
    end
  end

  // rounding: the magnitude of a negative product rounds up
  assign q   = uop_i.sh16 ? {16'd0, acc_q[AccW-1:16]} : acc_q;
  assign rem = uop_i.sh16 & (|acc_q[15:0]);
  assign qc  = q + {{(AccW-1){1'b0}}, neg_q & rem};

  always_ff @(posedge clk_i) begin
    if (uop_i.op == OP_FIN1) begin
      mag_q <= qc[ValW-1:0];
      big_q <= |qc[AccW-1:ValW];
    end
  end

  always_comb begin
    if (!neg_q) begin
      res = (big_q | mag_q[ValW-1]) ? SatMax : mag_q;
    end else begin
      res = (big_q | mag_q[ValW-1]) ? SatMin : (~mag_q + 64'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (uop_i.op == OP_FIN2) begin
      case (uop_i.dst)
        DST_K:   k_q  <= res[KW-1:0];
        DST_S2:  s2_q <= res[S2W-1:0];
        DST_TX:  tx_q <= res[TW-1:0];
        DST_TY:  ty_q <= res[TW-1:0];
        DST_FX:  fx_q <= res;
        DST_FY:  fy_q <= res;
        DST_M:   m_q  <= res;
        DST_CX:  cx_q <= res;
        DST_CY:  cy_q <= res;
        DST_CM:  cm_q <= res;
        default: ;
      endcase
    end
  end

  // saturating add of one term into its running sum
  always_comb begin
    case (uop_i.dst)
      DST_FX: begin
        sum_a = sfx_q;
        sum_b = fx_q;
      end
      DST_FY: begin
        sum_a = sfy_q;
        sum_b = fy_q;
      end
      default: begin
        sum_a = sm_q;
        sum_b = m_q;
      end
    endcase
    sum_s   = sum_a + sum_b;
    sum_ovf = (sum_a[ValW-1] == sum_b[ValW-1]) && (sum_s[ValW-1] != sum_a[ValW-1]);
    sum_r   = sum_ovf ? (sum_a[ValW-1] ? SatMin : SatMax) : sum_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sfx_q <= '0;
      sfy_q <= '0;
      sm_q  <= '0;
    end else if (uop_i.op == OP_EMIT) begin
      sfx_q <= '0;
      sfy_q <= '0;
      sm_q  <= '0;
    end else if (uop_i.op == OP_SUM) begin
      case (uop_i.dst)
        DST_FX:  sfx_q <= sum_r;
        DST_FY:  sfy_q <= sum_r;
        default: sm_q  <= sum_r;
      endcase
    end
  end

  assign stat_o.fx_le0 = fx_q[ValW-1] | (fx_q == '0);
  assign stat_o.fy_le0 = fy_q[ValW-1] | (fy_q == '0);

  assign sum_fx_o = sfx_q;
  assign sum_fy_o = sfy_q;
  assign sum_m_o  = sm_q;
  assign coef_x_o = cx_q;
  assign coef_y_o = cy_q;
  assign coef_m_o = cm_q;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: force and moment accumulator testbench
// Drives particle sets through the valid/ready channels, reprograms the APB
// registers between sets and checks every totals word against a predictor.
// ----------------------------------------------------------------------------
module tb;
  import pfma_pkg::*;

  localparam logic [PosW-1:0]  One     = 32'h0001_0000;
  localparam logic [PosW-1:0]  NegOne  = 32'hFFFF_0000;
  localparam logic [PosW-1:0]  MaxPos  = 32'h7FFF_FFFF;
  localparam logic [PosW-1:0]  MinPos  = 32'h8000_0000;
  localparam logic [SizeW-1:0] MaxSize = 31'h7FFF_FFFF;
  localparam logic [ChiW-1:0]  MaxMask = 17'h1_FFFF;
  localparam logic [ChiW-1:0]  OneMask = 17'h1_0000;
  localparam logic [DataW-1:0] MaxNorm = 32'h7FFF_FFFF;
  localparam logic [AddrW-1:0] UnusedAddr = 5'd28;
  localparam int unsigned RandomPhases = 12;
  localparam int unsigned PhaseItems   = 150;
  localparam int unsigned DrainCycles  = 90;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x, pos_y, vel_u, vel_v;
    logic [SizeW-1:0]       core_size;
    logic [ChiW-1:0]        solid_mask;
    logic                   last_particle;
  } particle_t;

  typedef struct packed {
    logic signed [ValW-1:0] force_x, force_y, moment, coeff_x, coeff_y, coeff_m;
  } totals_t;

  // predicts the totals of each particle set and checks the emitted words
  class force_integral_model;
    bit                     use_chi;
    logic signed [ValW-1:0] gain, center_x, center_y, inv_x, inv_y, inv_m;
    logic signed [ValW-1:0] acc_fx, acc_fy, acc_m;
    totals_t                pending_totals[$];
    int unsigned            mismatches;

    function new();
      use_chi    = 1'b1;
      gain       = 65536;
      center_x   = 0;
      center_y   = 0;
      inv_x      = 65536;
      inv_y      = 65536;
      inv_m      = 65536;
      acc_fx     = 0;
      acc_fy     = 0;
      acc_m      = 0;
      mismatches = 0;
    endfunction

    // floor(a*b / 2^sh), clamped to 64 bits
    function logic signed [ValW-1:0] q_mul(logic signed [ValW-1:0] a, logic signed [ValW-1:0] b,
                                           int unsigned sh);
      logic signed [AccW-1:0] wa, wb, p;
      wa = {{(AccW-ValW){a[ValW-1]}}, a};
      wb = {{(AccW-ValW){b[ValW-1]}}, b};
      p  = (wa * wb) >>> sh;
      if (p[AccW-1:ValW-1] == '0 || p[AccW-1:ValW-1] == '1) return p[ValW-1:0];
      return p[AccW-1] ? SatMin : SatMax;
    endfunction

    function logic signed [ValW-1:0] sat_sum(logic signed [ValW-1:0] a,
                                             logic signed [ValW-1:0] b);
      logic signed [ValW:0] t;
      t = $signed({a[ValW-1], a}) + $signed({b[ValW-1], b});
      if (t[ValW] != t[ValW-1]) return t[ValW] ? SatMin : SatMax;
      return t[ValW-1:0];
    endfunction

    function void set_register(reg_idx_e idx, logic [DataW-1:0] value);
      case (idx)
        REG_USE_CHI:    use_chi  = value[0];
        REG_FORCE_GAIN: gain     = {{(ValW-DataW){value[DataW-1]}}, value};
        REG_CENTER_X:   center_x = {{(ValW-DataW){value[DataW-1]}}, value};
        REG_CENTER_Y:   center_y = {{(ValW-DataW){value[DataW-1]}}, value};
        REG_INV_NORM_X: inv_x    = {33'b0, value[InvW-1:0]};
        REG_INV_NORM_Y: inv_y    = {33'b0, value[InvW-1:0]};
        REG_INV_NORM_M: inv_m    = {33'b0, value[InvW-1:0]};
        default: ;
      endcase
    endfunction

    function void take_particle(particle_t p);
      logic signed [ValW-1:0] k, s, s2, fx, fy, px, py, u, v;
      totals_t t;
      px = {{(ValW-PosW){p.pos_x[PosW-1]}}, p.pos_x};
      py = {{(ValW-PosW){p.pos_y[PosW-1]}}, p.pos_y};
      u  = {{(ValW-PosW){p.vel_u[PosW-1]}}, p.vel_u};
      v  = {{(ValW-PosW){p.vel_v[PosW-1]}}, p.vel_v};
      s  = {33'b0, p.core_size};
      s2 = s * s;
      k  = use_chi ? q_mul(gain, {47'b0, p.solid_mask}, 16) : gain;
      fx = q_mul(q_mul(k, u, 16), s2, 16);
      fy = q_mul(q_mul(k, v, 16), s2, 16);
      acc_fx = sat_sum(acc_fx, fx);
      acc_fy = sat_sum(acc_fy, fy);
      // only pushing components contribute a lever-arm moment
      if (fy > 0) acc_m = sat_sum(acc_m, q_mul(fy, center_x - px, 16));
      if (fx > 0) acc_m = sat_sum(acc_m, q_mul(fx, py - center_y, 16));
      if (p.last_particle) begin
        t.force_x = acc_fx;
        t.force_y = acc_fy;
        t.moment  = acc_m;
        t.coeff_x = q_mul(acc_fx, inv_x, 16);
        t.coeff_y = q_mul(acc_fy, inv_y, 16);
        t.coeff_m = q_mul(acc_m, inv_m, 16);
        pending_totals.push_back(t);
        acc_fx = 0;
        acc_fy = 0;
        acc_m  = 0;
      end
    endfunction

    function void compare(string field, logic signed [ValW-1:0] want,
                          logic signed [ValW-1:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_totals(totals_t got);
      totals_t want;
      if (pending_totals.size() == 0) begin
        $error("totals word with no particle set pending");
        mismatches++;
        return;
      end
      want = pending_totals.pop_front();
      compare("total_force_x", want.force_x, got.force_x);
      compare("total_force_y", want.force_y, got.force_y);
      compare("total_moment", want.moment, got.moment);
      compare("coeff_x", want.coeff_x, got.coeff_x);
      compare("coeff_y", want.coeff_y, got.coeff_y);
      compare("coeff_m", want.coeff_m, got.coeff_m);
    endfunction
  endclass

  logic             clk;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  bit               steady;

  force_integral_model integral = new();

  pfma_in_if  particle_ch ();
  pfma_out_if totals_ch ();

  penalization_force_moment_accumulator dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (particle_ch),
    .out_o   (totals_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // result side back-pressure
  initial begin
    totals_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      totals_ch.ready = steady || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin : watch_channels
    particle_t p;
    totals_t   t;
    if (totals_ch.valid && totals_ch.ready) begin
      t.force_x = totals_ch.total_force_x;
      t.force_y = totals_ch.total_force_y;
      t.moment  = totals_ch.total_moment;
      t.coeff_x = totals_ch.coeff_x;
      t.coeff_y = totals_ch.coeff_y;
      t.coeff_m = totals_ch.coeff_m;
      integral.check_totals(t);
    end
    if (particle_ch.valid && particle_ch.ready) begin
      p.pos_x         = particle_ch.pos_x;
      p.pos_y         = particle_ch.pos_y;
      p.vel_u         = particle_ch.vel_u;
      p.vel_v         = particle_ch.vel_v;
      p.core_size     = particle_ch.core_size;
      p.solid_mask    = particle_ch.solid_mask;
      p.last_particle = particle_ch.last_particle;
      integral.take_particle(p);
    end
  end

  // entered and left at a falling edge
  task automatic apb_write(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_register(reg_idx_e idx, logic [DataW-1:0] value);
    apb_write({idx, 2'b00}, value);
    integral.set_register(idx, value);
  endtask

  task automatic apply_settings(bit chi_on, logic [DataW-1:0] gain, logic [DataW-1:0] cx,
                                logic [DataW-1:0] cy, logic [DataW-1:0] nx,
                                logic [DataW-1:0] ny, logic [DataW-1:0] nm);
    write_register(REG_USE_CHI, {31'b0, chi_on});
    write_register(REG_FORCE_GAIN, gain);
    write_register(REG_CENTER_X, cx);
    write_register(REG_CENTER_Y, cy);
    write_register(REG_INV_NORM_X, nx);
    write_register(REG_INV_NORM_Y, ny);
    write_register(REG_INV_NORM_M, nm);
  endtask

  // valid stays high into the next word unless a gap is drawn
  task automatic send_particle(particle_t p);
    while (!steady && $urandom_range(99) < 27) begin
      particle_ch.valid = 1'b0;
      @(negedge clk);
    end
    particle_ch.pos_x         = p.pos_x;
    particle_ch.pos_y         = p.pos_y;
    particle_ch.vel_u         = p.vel_u;
    particle_ch.vel_v         = p.vel_v;
    particle_ch.core_size     = p.core_size;
    particle_ch.solid_mask    = p.solid_mask;
    particle_ch.last_particle = p.last_particle;
    particle_ch.valid         = 1'b1;
    do @(posedge clk); while (!particle_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    particle_ch.valid = 1'b0;
    while (integral.pending_totals.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic particle_t mk(logic [PosW-1:0] px, logic [PosW-1:0] py,
                                   logic [PosW-1:0] u, logic [PosW-1:0] v,
                                   logic [SizeW-1:0] s, logic [ChiW-1:0] chi, bit last);
    particle_t p;
    p.pos_x         = px;
    p.pos_y         = py;
    p.vel_u         = u;
    p.vel_v         = v;
    p.core_size     = s;
    p.solid_mask    = chi;
    p.last_particle = last;
    return p;
  endfunction

  function automatic logic [PosW-1:0] rand_q16();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return MaxPos;
          1: return MinPos;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return $urandom;
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  function automatic logic [SizeW-1:0] rand_size();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? MaxSize : '0;
      1: return 31'($urandom);
      default: return 31'($urandom_range(0, 1 << 17));
    endcase
  endfunction

  function automatic logic [ChiW-1:0] rand_mask();
    case ($urandom_range(9))
      0: return '0;
      1: return OneMask;
      2: return 17'($urandom_range(65537, MaxMask));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_gain();
    logic [DataW-1:0] g;
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? MaxPos : MinPos;
      default: begin
        g = $urandom_range(1 << 14, 1 << 18);
        return $urandom_range(1) ? -g : g;
      end
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_norm();
    case ($urandom_range(7))
      0: return $urandom & MaxNorm;
      1: return $urandom_range(1) ? MaxNorm : '0;
      default: return $urandom_range(0, 1 << 18);
    endcase
  endfunction

  initial begin
    int unsigned count, len;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    steady  = 1'b0;
    particle_ch.valid         = 1'b0;
    particle_ch.pos_x         = '0;
    particle_ch.pos_y         = '0;
    particle_ch.vel_u         = '0;
    particle_ch.vel_v         = '0;
    particle_ch.core_size     = '0;
    particle_ch.solid_mask    = '0;
    particle_ch.last_particle = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // reset settings: zero set, extreme positions, mask above one, saturation
    send_particle(mk('0, '0, '0, '0, '0, '0, 1'b1));
    send_particle(mk(MaxPos, MaxPos, One, One, One[SizeW-1:0], OneMask, 1'b0));
    send_particle(mk(MinPos, MinPos, NegOne, NegOne, One[SizeW-1:0], OneMask, 1'b1));
    send_particle(mk(One, NegOne, One, NegOne, 31'h2_0000, MaxMask, 1'b1));
    send_particle(mk(One, One, MaxPos, MaxPos, MaxSize, OneMask, 1'b0));
    send_particle(mk(NegOne, One, MaxPos, MaxPos, MaxSize, OneMask, 1'b0));
    send_particle(mk('0, '0, NegOne, NegOne, One[SizeW-1:0], OneMask, 1'b1));
    send_particle(mk(MinPos, MaxPos, MinPos, MinPos, MaxSize, MaxMask, 1'b0));
    send_particle(mk(MaxPos, MinPos, MaxPos, MaxPos, MaxSize, MaxMask, 1'b1));
    drain();

    // write to an unmapped address, which must leave the settings alone; all are rewritten next
    apb_write(UnusedAddr, '1);
    apply_settings(1'b0, MinPos, MaxPos, MinPos, '0, '0, '0);
    send_particle(mk(MaxPos, MinPos, NegOne, One, One[SizeW-1:0], '0, 1'b0));
    send_particle(mk(NegOne, One, One, NegOne, 31'h3_0000, '0, 1'b1));
    drain();

    apply_settings(1'b1, MaxPos, MinPos, MaxPos, MaxNorm, MaxNorm, MaxNorm);
    send_particle(mk(MinPos, MaxPos, One, One, One[SizeW-1:0], OneMask, 1'b0));
    send_particle(mk(One, One, '0, MinPos, 31'h8000, 17'h8000, 1'b1));
    send_particle(mk('0, '0, MaxPos, MaxPos, MaxSize, MaxMask, 1'b1));
    drain();

    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      apply_settings($urandom_range(1), rand_gain(), rand_q16(), rand_q16(),
                     rand_norm(), rand_norm(), rand_norm());
      steady = (ph == 5);
      count  = 0;
      while (count < PhaseItems) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
        for (int unsigned i = 0; i < len; i++) begin
          send_particle(mk(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_size(),
                           rand_mask(), i == len - 1));
          count++;
        end
      end
      drain();
    end

    if (integral.mismatches == 0 && integral.pending_totals.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
